// File: rtl/tga_pkg.sv
package tga_pkg;

	// Header layout and acceptance rules
	localparam logic [4:0] HEADER_BYTES = 5'd18;
	localparam logic [7:0] REQ_DEPTH    = 8'd32;
	localparam logic [7:0] REQ_TYPE     = 8'd10;
	localparam int         RUN_BIT      = 7;

	// Header byte positions that carry fields
	localparam logic [4:0] HB_ID_LEN   = 5'd0;
	localparam logic [4:0] HB_TYPE     = 5'd2;
	localparam logic [4:0] HB_WIDTH_LO = 5'd12;
	localparam logic [4:0] HB_WIDTH_HI = 5'd13;
	localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HB_DEPTH    = 5'd16;

	// Result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_SPAN    = 2'd1;
	localparam logic [1:0] KIND_BAD_HDR = 2'd2;
	localparam logic [1:0] KIND_OVERRUN = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PACKET,
		PH_COLOR
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] color;
		logic [15:0] start_column;
		logic [15:0] row;
		logic [7:0]  span_length;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        image_done;
	} out_item_t;

	// Result of one byte from the decoder core
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} core_res_t;

endpackage

// File: rtl/tga_rle_pixel_decoder.sv
// A byte passes the input register and the decoder core; its result is then offered from the result register.
// Throughput: one byte per cycle; the input register and the decoder core stall
//   only while a result waits in the output register and the consumer stalls.
// Bytes that complete no header, span or error give no result transaction.
// Reset (arst_n low, asynchronous) empties both registers and puts the decoder
//   idle, waiting for a byte with image_start set.
module tga_rle_pixel_decoder
	import tga_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic      item_valid_s1;
	in_item_t  item_s1;
	logic      result_valid_q;
	out_item_t result_q;
	logic      advance;
	core_res_t core_res;

	// The pipe moves unless a held result is being stalled
	assign advance    = !(result_valid_q && result_stall);
	assign item_stall = item_valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	tga_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (item_valid_s1 && advance),
		.item   (item_s1),
		.res    (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= core_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_res.item;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/tga_core.sv
module tga_core
	import tga_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  in_item_t  item,
	output core_res_t res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  hidx_q, hidx_d;
	logic [7:0]  id_len_q, id_len_d;
	logic [7:0]  img_type_q, img_type_d;
	logic [7:0]  depth_q, depth_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  skip_q, skip_d;
	logic [7:0]  pkt_rem_q, pkt_rem_d;
	logic        run_q, run_d;
	logic [31:0] color_q, color_d;
	logic [1:0]  cidx_q, cidx_d;
	logic [15:0] column_q, column_d;
	logic [15:0] crow_q, crow_d;

	logic [4:0]  hidx_inc;
	logic [7:0]  count;
	logic [16:0] reach;
	logic [7:0]  len;
	logic [7:0]  b;

	assign b = item.data_byte;

	// Next state and result for the byte in hand
	always_comb begin
		phase_d    = phase_q;
		hidx_d     = hidx_q;
		id_len_d   = id_len_q;
		img_type_d = img_type_q;
		depth_d    = depth_q;
		width_d    = width_q;
		height_d   = height_q;
		skip_d     = skip_q;
		pkt_rem_d  = pkt_rem_q;
		run_d      = run_q;
		color_d    = color_q;
		cidx_d     = cidx_q;
		column_d   = column_q;
		crow_d     = crow_q;
		res        = '0;
		hidx_inc   = '0;
		count      = {1'b0, b[6:0]} + 8'd1;
		reach      = '0;
		len        = '0;

		// start mark abandons any image and restarts the header
		if (item.image_start) begin
			phase_d    = PH_HEADER;
			hidx_d     = '0;
			id_len_d   = '0;
			img_type_d = '0;
			depth_d    = '0;
			width_d    = '0;
			height_d   = '0;
			skip_d     = '0;
			pkt_rem_d  = '0;
			run_d      = 1'b0;
			color_d    = '0;
			cidx_d     = '0;
			column_d   = '0;
			crow_d     = '0;
		end

		unique case (phase_d)
			PH_HEADER: begin
				unique case (hidx_d)
					HB_ID_LEN:    id_len_d        = b;
					HB_TYPE:      img_type_d      = b;
					HB_WIDTH_LO:  width_d[7:0]    = b;
					HB_WIDTH_HI:  width_d[15:8]   = b;
					HB_HEIGHT_LO: height_d[7:0]   = b;
					HB_HEIGHT_HI: height_d[15:8]  = b;
					HB_DEPTH:     depth_d         = b;
					default: ;
				endcase
				hidx_inc = hidx_d + 5'd1;
				hidx_d   = hidx_inc;
				if (hidx_inc == HEADER_BYTES) begin
					hidx_d    = '0;
					res.valid = 1'b1;
					if (depth_d != REQ_DEPTH || img_type_d != REQ_TYPE) begin
						phase_d             = PH_IDLE;
						res.item.kind       = KIND_BAD_HDR;
						res.item.image_done = 1'b1;
					end else begin
						res.item.kind         = KIND_HEADER;
						res.item.image_width  = width_d;
						res.item.image_height = height_d;
						column_d              = '0;
						if (width_d == '0 || height_d == '0) begin
							phase_d             = PH_IDLE;
							res.item.image_done = 1'b1;
						end else begin
							crow_d  = height_d - 16'd1;
							skip_d  = id_len_d;
							phase_d = (id_len_d != '0) ? PH_SKIP : PH_PACKET;
						end
					end
				end
			end

			PH_SKIP: begin
				skip_d = skip_d - 8'd1;
				if (skip_d == '0) begin
					phase_d = PH_PACKET;
				end
			end

			PH_PACKET: begin
				reach = {1'b0, column_d} + {9'd0, count};
				if (reach > {1'b0, width_d}) begin
					phase_d             = PH_IDLE;
					res.valid           = 1'b1;
					res.item.kind       = KIND_OVERRUN;
					res.item.image_done = 1'b1;
				end else begin
					pkt_rem_d = count;
					run_d     = b[RUN_BIT];
					cidx_d    = '0;
					color_d   = '0;
					phase_d   = PH_COLOR;
				end
			end

			PH_COLOR: begin
				color_d[{cidx_d, 3'b000} +: 8] = color_d[{cidx_d, 3'b000} +: 8] | b;
				if (cidx_d != 2'd3) begin
					cidx_d = cidx_d + 2'd1;
				end else begin
					cidx_d                = '0;
					len                   = run_d ? pkt_rem_d : 8'd1;
					res.valid             = 1'b1;
					res.item.kind         = KIND_SPAN;
					res.item.color        = color_d;
					res.item.start_column = column_d;
					res.item.row          = crow_d;
					res.item.span_length  = len;
					column_d              = column_d + {8'd0, len};
					pkt_rem_d             = pkt_rem_d - len;
					color_d               = '0;
					if (pkt_rem_d == '0) begin
						phase_d = PH_PACKET;
						// row complete: move one row up, or finish at the top
						if (column_d >= width_d) begin
							column_d = '0;
							if (crow_d == '0) begin
								phase_d             = PH_IDLE;
								res.item.image_done = 1'b1;
							end else begin
								crow_d = crow_d - 16'd1;
							end
						end
					end
				end
			end

			PH_IDLE: ;

			default: ;
		endcase

		if (!en) begin
			res = '0;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hidx_q     <= '0;
			id_len_q   <= '0;
			img_type_q <= '0;
			depth_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			skip_q     <= '0;
			pkt_rem_q  <= '0;
			run_q      <= 1'b0;
			color_q    <= '0;
			cidx_q     <= '0;
			column_q   <= '0;
			crow_q     <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			hidx_q     <= hidx_d;
			id_len_q   <= id_len_d;
			img_type_q <= img_type_d;
			depth_q    <= depth_d;
			width_q    <= width_d;
			height_q   <= height_d;
			skip_q     <= skip_d;
			pkt_rem_q  <= pkt_rem_d;
			run_q      <= run_d;
			color_q    <= color_d;
			cidx_q     <= cidx_d;
			column_q   <= column_d;
			crow_q     <= crow_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_hidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hidx_q < HEADER_BYTES)
		else $error("header index out of range");

	a_color_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLOR) |-> (pkt_rem_q != '0))
		else $error("color phase with no pixels left in packet");

	a_column_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP || phase_q == PH_PACKET || phase_q == PH_COLOR)
		|-> (column_q < width_q && crow_q < height_q))
		else $error("column or row outside the image");

	a_cidx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_COLOR) |-> (cidx_q == '0))
		else $error("color byte index left over outside color phase");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tga_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 1300;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	in_item_t  pending_bytes[$];
	out_item_t expected_records[$];
	int        cycle_count = 0;
	int        error_count = 0;

	// Decoder state mirrored on the testbench side
	phase_t      dec_phase;
	logic [4:0]  hdr_index;
	logic [7:0]  id_len;
	logic [7:0]  img_type;
	logic [7:0]  px_depth;
	logic [7:0]  skip_left;
	logic [7:0]  pkt_left;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [15:0] col;
	logic [15:0] cur_row;
	logic        is_run;
	logic [31:0] color_acc;
	logic [1:0]  color_idx;

	tga_rle_pixel_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	function automatic void clear_decoder();
		dec_phase = PH_IDLE;
		hdr_index = '0;
		id_len    = '0;
		img_type  = '0;
		px_depth  = '0;
		skip_left = '0;
		pkt_left  = '0;
		img_w     = '0;
		img_h     = '0;
		col       = '0;
		cur_row   = '0;
		is_run    = 1'b0;
		color_acc = '0;
		color_idx = '0;
	endfunction

	// Advance the decoder by one file byte; returns 1 when a record comes out
	function automatic bit decode_byte(input in_item_t it, output out_item_t res);
		logic [16:0] count;
		logic [7:0]  len;
		res = '0;
		if (it.image_start) begin
			clear_decoder();
			dec_phase = PH_HEADER;
		end
		case (dec_phase)
			PH_HEADER: begin
				case (hdr_index)
					HB_ID_LEN:    id_len = it.data_byte;
					HB_TYPE:      img_type = it.data_byte;
					HB_WIDTH_LO:  img_w[7:0] = it.data_byte;
					HB_WIDTH_HI:  img_w[15:8] = it.data_byte;
					HB_HEIGHT_LO: img_h[7:0] = it.data_byte;
					HB_HEIGHT_HI: img_h[15:8] = it.data_byte;
					HB_DEPTH:     px_depth = it.data_byte;
					default: ;
				endcase
				hdr_index = hdr_index + 5'd1;
				if (hdr_index < HEADER_BYTES)
					return 1'b0;
				hdr_index = '0;
				if (px_depth != REQ_DEPTH || img_type != REQ_TYPE) begin
					dec_phase = PH_IDLE;
					res.kind = KIND_BAD_HDR;
					res.image_done = 1'b1;
					return 1'b1;
				end
				res.kind = KIND_HEADER;
				res.image_width = img_w;
				res.image_height = img_h;
				col = '0;
				// empty image ends right at the header
				if (img_w == 16'd0 || img_h == 16'd0) begin
					dec_phase = PH_IDLE;
					res.image_done = 1'b1;
					return 1'b1;
				end
				cur_row = img_h - 16'd1;
				skip_left = id_len;
				dec_phase = (id_len != 8'd0) ? PH_SKIP : PH_PACKET;
				return 1'b1;
			end
			PH_SKIP: begin
				skip_left = skip_left - 8'd1;
				if (skip_left == 8'd0)
					dec_phase = PH_PACKET;
				return 1'b0;
			end
			PH_PACKET: begin
				count = 17'(it.data_byte[6:0]) + 17'd1;
				if (17'(col) + count > 17'(img_w)) begin
					dec_phase = PH_IDLE;
					res.kind = KIND_OVERRUN;
					res.image_done = 1'b1;
					return 1'b1;
				end
				pkt_left = count[7:0];
				is_run = it.data_byte[RUN_BIT];
				color_idx = '0;
				color_acc = '0;
				dec_phase = PH_COLOR;
				return 1'b0;
			end
			PH_COLOR: begin
				color_acc = color_acc | (32'(it.data_byte) << {color_idx, 3'b000});
				if (color_idx != 2'd3) begin
					color_idx = color_idx + 2'd1;
					return 1'b0;
				end
				color_idx = '0;
				len = is_run ? pkt_left : 8'd1;
				res.kind = KIND_SPAN;
				res.color = color_acc;
				res.start_column = col;
				res.row = cur_row;
				res.span_length = len;
				col = col + 16'(len);
				pkt_left = pkt_left - len;
				color_acc = '0;
				if (pkt_left != 8'd0)
					return 1'b1;
				dec_phase = PH_PACKET;
				// row complete: move up, or finish after the top row
				if (col >= img_w) begin
					col = '0;
					if (cur_row == 16'd0) begin
						dec_phase = PH_IDLE;
						res.image_done = 1'b1;
					end else begin
						cur_row = cur_row - 16'd1;
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Random back-pressure and gaps, with a quiet window of full rate
	function automatic bit take_break();
		if (cycle_count >= 600 && cycle_count < 1100)
			return 1'b0;
		return $urandom_range(0, 99) < 6;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 100)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Stream building
	task automatic push_byte(input logic [7:0] b, input logic start = 1'b0);
		in_item_t it;
		it.data_byte = b;
		it.image_start = start;
		pending_bytes.push_back(it);
	endtask

	function automatic logic [31:0] pick_color();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_color(input logic [31:0] c);
		for (int i = 0; i < 4; i++)
			push_byte(c[8*i +: 8]);
	endtask

	// Header plus the ID bytes that follow it
	task automatic push_header(input logic [7:0] id, input logic [7:0] typ,
			input logic [7:0] depth, input logic [15:0] w, input logic [15:0] h);
		logic [7:0] hb;
		for (int i = 0; i < int'(HEADER_BYTES); i++) begin
			hb = 8'($urandom);
			case (5'(i))
				HB_ID_LEN:    hb = id;
				HB_TYPE:      hb = typ;
				HB_WIDTH_LO:  hb = w[7:0];
				HB_WIDTH_HI:  hb = w[15:8];
				HB_HEIGHT_LO: hb = h[7:0];
				HB_HEIGHT_HI: hb = h[15:8];
				HB_DEPTH:     hb = depth;
				default: ;
			endcase
			push_byte(hb, i == 0);
		end
		for (int i = 0; i < int'(id); i++)
			push_byte(8'($urandom));
	endtask

	task automatic push_packet(input int n, input bit run_flag);
		push_byte({run_flag, 7'(n - 1)});
		if (run_flag)
			push_color(pick_color());
		else
			repeat (n) push_color(pick_color());
	endtask

	// Packets that cover exactly cols pixels of one row
	task automatic fill_row(input int cols);
		int c, rem, cap, n;
		bit run_flag;
		c = 0;
		while (c < cols) begin
			rem = cols - c;
			run_flag = $urandom_range(0, 1);
			cap = run_flag ? ((rem < 128) ? rem : 128) : ((rem < 5) ? rem : 5);
			n = ($urandom_range(0, 3) == 0) ? cap : int'($urandom_range(1, cap));
			push_packet(n, run_flag);
			c += n;
		end
	endtask

	task automatic build_directed();
		// ignored before any image
		push_byte(8'h00);
		push_byte(8'hFF);
		// one row of a single maximum run
		push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'd128, 16'd1);
		push_byte(8'hFF);
		push_color(32'hFFFF_FFFF);
		// ID byte skipped, literal pair then a run
		push_header(8'd1, REQ_TYPE, REQ_DEPTH, 16'd2, 16'd2);
		push_byte(8'h01);
		push_color(32'h0000_0000);
		push_color(32'h8040_2010);
		push_byte(8'h81);
		push_color(32'h0102_0304);
		push_byte(8'h55);
		// rejected headers
		push_header(8'd0, REQ_TYPE, 8'd24, 16'd4, 16'd4);
		push_header(8'd0, 8'hFF, 8'h00, 16'd4, 16'd4);
		// empty images at the size extremes
		push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'hFFFF, 16'd0);
		push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'd0, 16'hFFFF);
		// literal of two in a one-pixel row
		push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'd1, 16'd3);
		push_byte(8'h01);
		// very tall image, abandoned in the middle of a colour
		push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'd1, 16'hFFFF);
		push_byte(8'h80);
		push_color(32'hDEAD_BEEF);
		push_byte(8'h00);
		push_byte(8'h12);
	endtask

	task automatic build_random();
		int w, h, p, n, start_size, keep, counted;
		logic [7:0] typ, depth, id;
		counted = 0;
		while (counted < RANDOM_BYTES) begin
			start_size = pending_bytes.size();
			case ($urandom_range(0, 19))
				// stray bytes, ignored or eaten by an unfinished image
				0: begin
					repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
					continue;
				end
				1, 2: begin
					typ = ($urandom_range(0, 1) != 0) ? REQ_TYPE : 8'($urandom);
					depth = ($urandom_range(0, 3) == 0) ? REQ_DEPTH : 8'($urandom);
					if (typ == REQ_TYPE && depth == REQ_DEPTH)
						depth = REQ_DEPTH ^ (8'd1 << $urandom_range(0, 7));
					push_header(8'($urandom_range(0, 2)), typ, depth, 16'($urandom),
						16'($urandom));
				end
				3: begin
					if ($urandom_range(0, 1) != 0)
						push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'd0, 16'($urandom));
					else
						push_header(8'd0, REQ_TYPE, REQ_DEPTH, 16'($urandom), 16'd0);
				end
				4, 5: begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 3);
					push_header(8'($urandom_range(0, 2)), REQ_TYPE, REQ_DEPTH, 16'(w), 16'(h));
					repeat ($urandom_range(0, h - 1)) fill_row(w);
					p = $urandom_range(0, w - 1);
					fill_row(p);
					n = $urandom_range(w - p + 1, 128);
					push_byte({1'($urandom_range(0, 1)), 7'(n - 1)});
				end
				default: begin
					case ($urandom_range(0, 9))
						0:       w = $urandom_range(129, 400);
						1, 2:    w = $urandom_range(9, 128);
						default: w = $urandom_range(1, 8);
					endcase
					h = (w > 128) ? int'($urandom_range(1, 2)) : int'($urandom_range(1, 5));
					id = ($urandom_range(0, 49) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
					push_header(id, REQ_TYPE, REQ_DEPTH, 16'(w), 16'(h));
					repeat (h) fill_row(w);
					// sometimes cut short, to be aborted by what follows
					if ($urandom_range(0, 7) == 0) begin
						keep = start_size +
							$urandom_range(1, pending_bytes.size() - start_size - 1);
						while (pending_bytes.size() > keep)
							void'(pending_bytes.pop_back());
					end
				end
			endcase
			counted += pending_bytes.size() - start_size;
		end
	endtask

	// Cycle counter and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[tga_rle_pixel_decoder] ERROR");
			$finish;
		end
	end

	// Byte driver; each accepted transaction goes through the predictor
	always @(posedge clk) begin
		out_item_t res;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				if (decode_byte(item, res))
					expected_records.push_back(res);
			end
			if (!item_valid || !item_stall) begin
				if (pending_bytes.size() != 0 && !take_break()) begin
					item <= pending_bytes.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and stall generator
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			result_stall <= take_break();
			if (result_valid && !result_stall) begin
				if (expected_records.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					want = expected_records.pop_front();
					check_field("kind", 32'(result.kind), 32'(want.kind));
					check_field("color", result.color, want.color);
					check_field("start_column", 32'(result.start_column),
						32'(want.start_column));
					check_field("row", 32'(result.row), 32'(want.row));
					check_field("span_length", 32'(result.span_length),
						32'(want.span_length));
					check_field("image_width", 32'(result.image_width),
						32'(want.image_width));
					check_field("image_height", 32'(result.image_height),
						32'(want.image_height));
					check_field("image_done", 32'(result.image_done),
						32'(want.image_done));
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		clear_decoder();
		build_directed();
		build_random();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk); while (pending_bytes.size() != 0 || item_valid);
		while (expected_records.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0 && expected_records.size() == 0) begin
			$display("[tga_rle_pixel_decoder] OK");
		end else begin
			$display("[tga_rle_pixel_decoder] ERROR");
		end
		$finish;
	end

endmodule
